// ===== rtl/core/ordered_array_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array list engine
// Each macro expands to one labeled concurrent assertion on clock and reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OALE_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OALE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/core/oale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Types and constants shared by the list cells, the result stage and the top.
// ----------------------------------------------------------------------------
package oale_pkg;

   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_FULL         = 2'd1,
      ST_BAD_POSITION = 2'd2,
      ST_NOT_FOUND    = 2'd3
   } status_type;

   typedef struct packed {
      op_type                     operation;
      logic signed [VALUE_W-1:0]  value;
      logic        [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic        [IDX_W-1:0]    found_position;
      logic        [CNT_W-1:0]    element_count;
   } rsp_type;

   // Command broadcast to every cell of the list.
   typedef struct packed {
      logic                       shift_up;
      logic                       shift_down;
      logic                       find;
      logic        [POS_W-1:0]    position;
      logic signed [VALUE_W-1:0]  value;
      logic        [CNT_W-1:0]    count;
   } cell_cmd_type;

   // Request context carried from the cell row to the result stage.
   typedef struct packed {
      logic                       valid;
      logic                       find;
      status_type                 status;
      logic        [CNT_W-1:0]    count;
   } stage_type;

endpackage

// ===== rtl/core/ordered_array_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine
// Ordered list of signed 32-bit values with find, insert and delete requests.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                  Direction  Handshake
//   request   start, busy, req_item  in         beat taken when start and !busy
//   result    rsp_strobe, rsp_item   out        one-cycle strobe, no back-pressure
//
// Every request gives exactly one result beat. The request is registered in
// the stage register and the cells' match bits, and the result stage then
// registers the result beat and its strobe. A new request can be taken in
// every cycle while busy is low: the row of cells compares or shifts all
// entries at once at the request edge.
// Busy is high while reset is held and in the cycle after reset; reset empties the list.
// The receiver cannot stall, so nothing inside ever waits on the result side.
//
// Structure: a row of CAPACITY cells, one per list position. On insert each
// cell above the position takes its left neighbor's entry and the cell at the
// position takes the new value; on delete each cell from the position up
// takes its right neighbor's entry. On find every occupied cell compares its
// entry and registers a match bit, and the result stage picks the lowest one.
// ----------------------------------------------------------------------------
module ordered_array_list_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  oale_pkg::req_type    req_item,
   output logic                 rsp_strobe,
   output oale_pkg::rsp_type    rsp_item
);
   import oale_pkg::*;

`include "ordered_array_list_engine_macros.svh"

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic                      busy_ff;
   logic                      accept;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   stage_type                 stage_ff;
   stage_type                 stage_in;
   cell_cmd_type              cmd;
   logic [CAPACITY-1:0]       hit_mask;
   logic signed [VALUE_W-1:0] entries_w [CAPACITY];

   // The request beat is taken whenever the block is not coming out of reset.
   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // Decode the request against the current count. Only a legal insert or
   // delete moves entries; every other outcome leaves the list unchanged.
   always_comb begin
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      cmd.find       = 1'b0;
      cmd.position   = req_item.position;
      cmd.value      = req_item.value;
      cmd.count      = count_ff;
      count_in       = count_ff;
      stage_in.valid  = accept;
      stage_in.find   = 1'b0;
      stage_in.status = ST_OK;
      unique case (req_item.operation)
         OP_FIND: begin
            cmd.find      = accept;
            stage_in.find = 1'b1;
         end
         OP_INSERT: begin
            // A full list is reported before the position is checked.
            if (count_ff == FULL_COUNT) begin
               stage_in.status = ST_FULL;
            end else if (req_item.position > POS_W'(count_ff)) begin
               stage_in.status = ST_BAD_POSITION;
            end else begin
               cmd.shift_up = accept;
               if (accept) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         OP_DELETE: begin
            if (req_item.position >= POS_W'(count_ff)) begin
               stage_in.status = ST_BAD_POSITION;
            end else begin
               cmd.shift_down = accept;
               if (accept) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         OP_UNUSED: begin
            stage_in.status = ST_BAD_POSITION;
         end
      endcase
      stage_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         count_ff       <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         busy_ff        <= 1'b0;
         count_ff       <= count_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.find   <= stage_in.find;
      stage_ff.status <= stage_in.status;
      stage_ff.count  <= stage_in.count;
   end

   // Row of cells. The bottom cell's left input and the top cell's right
   // input are never selected in a way that reaches an occupied position.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_w;
      logic signed [VALUE_W-1:0] right_w;

      if (g == 0) begin : g_bottom
         assign left_w = req_item.value;
      end else begin : g_left
         assign left_w = entries_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_top
         assign right_w = entries_w[g];
      end else begin : g_right
         assign right_w = entries_w[g+1];
      end

      oale_cell #(
         .INDEX       (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entries_w[g]),
         .match       (hit_mask[g])
      );
   end

   oale_result u_result (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage_ff),
      .hit_mask   (hit_mask),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   `OALE_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= FULL_COUNT, "list count above capacity")
   `OALE_ASSERT_NEXT(a_count_hold, !accept, $stable(count_ff), "count moved without a request")
   `OALE_ASSERT_NEXT(a_one_result, stage_ff.valid, rsp_strobe, "request lost before the result beat")
   `OALE_ASSERT_SAME(a_miss_pos, rsp_strobe && rsp_item.status != ST_OK, rsp_item.found_position == '0, "position reported without a hit")

endmodule

// ===== rtl/core/oale_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list cell
// Holds one list entry, shifts with its neighbors and flags a find match.
// ----------------------------------------------------------------------------
module oale_cell #(
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  oale_pkg::cell_cmd_type             cmd,
   input  logic signed [oale_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [oale_pkg::VALUE_W-1:0] right_entry,
   output logic signed [oale_pkg::VALUE_W-1:0] entry,
   output logic                               match
);
   import oale_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      match_ff;
   logic                      match_in;
   logic                      occupied;

   assign occupied = (MY_POS < POS_W'(cmd.count));

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_up) begin
         if (MY_POS > cmd.position) begin
            entry_in = left_entry;
         end else if (MY_POS == cmd.position) begin
            entry_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (MY_POS >= cmd.position) begin
            entry_in = right_entry;
         end
      end
   end

   assign match_in = cmd.find && occupied && (entry_ff == cmd.value);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== rtl/core/oale_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list result stage
// Encodes the lowest matching cell and registers the result beat.
// ----------------------------------------------------------------------------
module oale_result (
   input  logic                            clock,
   input  logic                            reset,
   input  oale_pkg::stage_type             stage,
   input  logic [oale_pkg::CAPACITY-1:0]   hit_mask,
   output logic                            rsp_strobe,
   output oale_pkg::rsp_type               rsp_item
);
   import oale_pkg::*;

   logic             strobe_ff;
   logic             strobe_in;
   rsp_type          item_ff;
   rsp_type          item_in;
   logic [IDX_W-1:0] lowest;

   // Scanning from the top leaves the lowest set bit's index.
   always_comb begin
      lowest = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit_mask[i]) begin
            lowest = IDX_W'(i);
         end
      end
   end

   always_comb begin
      strobe_in              = stage.valid;
      item_in.status         = stage.status;
      item_in.found_position = '0;
      item_in.element_count  = stage.count;
      if (stage.find) begin
         if (|hit_mask) begin
            item_in.status         = ST_OK;
            item_in.found_position = lowest;
         end else begin
            item_in.status = ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      item_ff <= item_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = item_ff;

endmodule
